// File: hw/rtl/priority_task_scheduler_top_macros.svh
// Assertion macros for the priority task scheduler.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef PRIORITY_TASK_SCHEDULER_TOP_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pts: implication check failed");

// Next-cycle implication, checked outside reset.
`define PTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pts: next-cycle check failed");

`endif

// File: hw/rtl/pts_pkg.sv
// Package for the priority task scheduler: field widths, codes, table entry type.
// No dependencies.
`default_nettype none

package pts_pkg;

  localparam int KEY_W   = 8;
  localparam int PRIO_W  = 4;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 22;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int MAX_TASKS_DEF = 32;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_SCHED = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/pts_table.sv
// Task table: single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on pts_pkg.
`default_nettype none

module pts_table
  import pts_pkg::*;
#(
  parameter int DEPTH = MAX_TASKS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire entry_t                   wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      entry_t                   rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/priority_task_scheduler_top.sv
// Priority task scheduler top level: control sequencer, result register, checks.
// Depends on pts_pkg, pts_table and priority_task_scheduler_top_macros.svh.
//
// Usage:
//   Input channel (in_*): in_mode = MODE_ADD stores a task in the next free
//   slot (dropped when the table is full); in_mode = MODE_SCHED dispatches all
//   stored tasks, highest priority first, ties to the smaller key, then to the
//   most recent add. A run emits one out_* transfer per task; out_last marks
//   the final one, which also carries the dispatcher time. The run empties
//   the table. An empty run and an add give no result.
//   Timing: a run with N tasks takes N picks, each a sweep of the table RAM
//   (N reads, one per cycle, then the read result, the end of the sweep and
//   the dispatch). New input is taken only between runs.
//   Reset: synchronous, active low; empties the table and drops any pending
//   result. No clearing pass is needed.
//   Stall: the result register holds while out_ready is low; the sweep for
//   the next pick proceeds and waits at dispatch until the register frees.
`default_nettype none
`include "priority_task_scheduler_top_macros.svh"

module priority_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_mode,
  input  wire logic [KEY_W-1:0]   in_task_key,
  input  wire logic [PRIO_W-1:0]  in_task_priority,
  input  wire logic [BURST_W-1:0] in_burst_length,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [KEY_W-1:0]   out_task_key_res,
  output      logic [PRIO_W-1:0]  out_task_priority_res,
  output      logic [BURST_W-1:0] out_burst_length_res,
  output      logic [TIME_W-1:0]  out_start_time,
  output      logic [TIME_W-1:0]  out_finish_time,
  output      logic [TIME_W-1:0]  out_dispatcher_time,
  output      logic               out_last
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     task_count_r, task_count_nxt;
  logic [MAX_TASKS-1:0] done_r, done_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  entry_t               best_r, best_nxt;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic [CNT_W-1:0]     nsent_r, nsent_nxt;
  logic                 out_valid_r, out_valid_nxt;
  entry_t               out_ent_r, out_ent_nxt;
  logic [TIME_W-1:0]    out_start_r, out_start_nxt;
  logic [TIME_W-1:0]    out_finish_r, out_finish_nxt;
  logic [TIME_W-1:0]    out_disp_r, out_disp_nxt;
  logic                 out_last_r, out_last_nxt;

  logic             wr_en;
  entry_t           wr_data;
  logic             rd_en;
  entry_t           rd_data;
  logic             in_xfer;
  logic             ld_out;
  logic             ld_last;
  logic [TIME_W:0]  fin_sum;
  logic [TIME_W-1:0] fin_sat;
  logic [TIME_W:0]  disp_sum;
  logic [TIME_W-1:0] disp_sat;
  logic [CNT_W-1:0] sent_inc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign wr_data.key   = in_task_key;
  assign wr_data.prio  = in_task_priority;
  assign wr_data.burst = in_burst_length;
  assign wr_en = in_xfer && (in_mode == MODE_ADD) && (task_count_r < CNT_W'(MAX_TASKS));

  assign rd_en = (state_r == ST_SCAN) && (scan_idx_r < task_count_r);

  pts_table #(
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (task_count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign fin_sum  = {1'b0, time_r} + {{(TIME_W + 1 - BURST_W){1'b0}}, best_r.burst};
  assign fin_sat  = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
  assign sent_inc = nsent_r + 1'b1;
  assign disp_sum = {1'b0, fin_sat} + {{(TIME_W + 1 - CNT_W){1'b0}}, sent_inc};
  assign disp_sat = disp_sum[TIME_W] ? TIME_MAX : disp_sum[TIME_W-1:0];

  assign ld_out  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign ld_last = ld_out && (sent_inc == task_count_r);

  always_comb begin
    state_nxt      = state_r;
    task_count_nxt = task_count_r;
    done_nxt       = done_r;
    scan_idx_nxt   = scan_idx_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = scan_idx_r[IDX_W-1:0];
    best_vld_nxt   = best_vld_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    time_nxt       = time_r;
    nsent_nxt      = nsent_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_ent_nxt    = out_ent_r;
    out_start_nxt  = out_start_r;
    out_finish_nxt = out_finish_r;
    out_disp_nxt   = out_disp_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (wr_en) begin
          task_count_nxt = task_count_r + 1'b1;
        end
        if (in_xfer && (in_mode == MODE_SCHED) && (task_count_r != '0)) begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          best_vld_nxt = 1'b0;
          time_nxt     = '0;
          nsent_nxt    = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          rd_vld_nxt   = 1'b1;
        end
        if (rd_vld_r && !done_r[rd_idx_r]) begin
          if (!best_vld_r || (rd_data.prio > best_r.prio) ||
              ((rd_data.prio == best_r.prio) && (rd_data.key <= best_r.key))) begin
            best_vld_nxt = 1'b1;
            best_idx_nxt = rd_idx_r;
            best_nxt     = rd_data;
          end
        end
        if (!rd_en && !rd_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ld_out) begin
          out_valid_nxt  = 1'b1;
          out_ent_nxt    = best_r;
          out_start_nxt  = time_r;
          out_finish_nxt = fin_sat;
          out_last_nxt   = ld_last;
          out_disp_nxt   = ld_last ? (disp_sat - 1'b1) : '0;
          time_nxt       = fin_sat;
          nsent_nxt      = sent_inc;
          done_nxt[best_idx_r] = 1'b1;
          if (ld_last) begin
            state_nxt      = ST_IDLE;
            task_count_nxt = '0;
            done_nxt       = '0;
          end else begin
            state_nxt    = ST_SCAN;
            scan_idx_nxt = '0;
            best_vld_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_count_r <= '0;
      done_r       <= '0;
      scan_idx_r   <= '0;
      rd_vld_r     <= 1'b0;
      best_vld_r   <= 1'b0;
      nsent_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      done_r       <= done_nxt;
      scan_idx_r   <= scan_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      best_vld_r   <= best_vld_nxt;
      nsent_r      <= nsent_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    rd_idx_r     <= rd_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    time_r       <= time_nxt;
    out_ent_r    <= out_ent_nxt;
    out_start_r  <= out_start_nxt;
    out_finish_r <= out_finish_nxt;
    out_disp_r   <= out_disp_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_task_key_res      = out_ent_r.key;
  assign out_task_priority_res = out_ent_r.prio;
  assign out_burst_length_res  = out_ent_r.burst;
  assign out_start_time        = out_start_r;
  assign out_finish_time       = out_finish_r;
  assign out_dispatcher_time   = out_disp_r;
  assign out_last              = out_last_r;

  `PTS_ASSERT_IMP(a_count_bound, 1'b1, task_count_r <= CNT_W'(MAX_TASKS))
  `PTS_ASSERT_IMP(a_emit_has_pick, state_r == ST_EMIT, best_vld_r)
  `PTS_ASSERT_NXT(a_run_clears, ld_last, (task_count_r == '0) && (done_r == '0))
  `PTS_ASSERT_IMP(a_disp_on_last, out_valid_r && !out_last_r, out_disp_r == '0)

endmodule

`default_nettype wire
